FILE: hdl/dtcgm_pkg.sv
// Package for the depth to color / gray mapper: payload types, stage record and helpers.
`default_nettype none
package dtcgm_pkg;

  localparam int RegW   = 31;
  localparam int DivSteps = 17;

  typedef enum logic [1:0] {
    CMD_JET   = 2'd0,
    CMD_GRAY  = 2'd1,
    CMD_DEPTH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ROBUST_MIN = 2'd0,
    REG_ROBUST_MAX = 2'd1,
    REG_CLAMP_MIN  = 2'd2,
    REG_CLAMP_MAX  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] depth_in;
    logic [7:0]         gray_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      blue;
    logic [7:0]      green;
    logic [7:0]      red;
    logic [7:0]      gray_out;
    logic [RegW-1:0] depth_out;
    logic            depth_write;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic            dvalid;
    logic            rpos;
    logic [31:0]     rem;
    logic [RegW-1:0] dsor;
    logic [16:0]     quo;
    logic            gnz;
    logic            neg;
    logic [7:0]      amag;
    logic [RegW-1:0] rmag;
    logic [39:0]     x;
    logic [1:0]      r3;
    logic [39:0]     q3;
  } pipe_t;

  // Piecewise-linear jet basis, signed Q2.16 in and Q1.16 out.
  function automatic logic [16:0] jet_base(input logic signed [18:0] v);
    logic signed [20:0] t;
    logic [16:0] b;
    t = 21'(v);
    if (v <= 19'sd8192) b = '0;
    else if (v <= 19'sd24576) begin
      t = (t <<< 2) - 21'sd32768;
      b = t[16:0];
    end else if (v <= 19'sd40960) b = 17'd65536;
    else if (v <= 19'sd57344) begin
      t = 21'sd229376 - (t <<< 2);
      b = t[16:0];
    end else b = '0;
    return b;
  endfunction

  function automatic logic [7:0] to_byte(input logic [16:0] b);
    logic [24:0] p;
    p = 25'(b) * 25'd255 + 25'd32768;
    return p[23:16];
  endfunction

  // One radix-256 digit of a division by three; returns {quotient digit, remainder}.
  function automatic logic [9:0] div3_digit(input logic [1:0] r, input logic [7:0] d);
    logic [9:0]  v;
    logic [20:0] p;
    logic [7:0]  q;
    logic [9:0]  rr;
    v  = {r, d};
    p  = 21'(v) * 21'd683;
    q  = p[18:11];
    rr = v - 10'(q) * 10'd3;
    return {q, rr[1:0]};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/depth_to_color_gray_mapper.sv
// Top level of the depth to color / gray mapper: a fully pipelined per-pixel datapath.
`default_nettype none
// One pixel is accepted per cycle while the output is taken. The pipeline depth
// is set by the normalizing divider, a pipelined restoring divider that
// resolves one of its 17 quotient bits in each stage; the gray to depth path
// (multiply, rounding, division by 192 in byte digits, clamping) runs alongside
// in the same stages. The whole pipeline holds when the output is not taken.
// Configuration writes are taken at any time and should be made while idle.
module depth_to_color_gray_mapper
  import dtcgm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [RegW-1:0] robust_min, robust_max, clamp_min, clamp_max;
  pipe_t st [0:DivSteps];
  logic  vld [0:DivSteps];
  pipe_t s0_next;
  logic  adv;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      robust_min <= '0;
      robust_max <= 31'd65536;
      clamp_min  <= '0;
      clamp_max  <= '1;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ROBUST_MIN: robust_min <= cfg_data[RegW-1:0];
        REG_ROBUST_MAX: robust_max <= cfg_data[RegW-1:0];
        REG_CLAMP_MIN:  clamp_min  <= cfg_data[RegW-1:0];
        REG_CLAMP_MAX:  clamp_max  <= cfg_data[RegW-1:0];
        default: ;
      endcase
    end
  end

  // Entry stage: clamp into the display range and split mode 2 into sign and magnitudes.
  always_comb begin
    logic [RegW-1:0]    d, rd;
    logic signed [8:0]  gd;
    logic signed [31:0] rs;
    logic [31:0]        rneg_mag;
    d  = in_data.depth_in[RegW-1:0];
    rd = (d > robust_max) ? robust_max : d;
    rd = (rd < robust_min) ? robust_min : rd;
    gd = $signed({1'b0, in_data.gray_in}) - 9'sd32;
    rs = $signed({1'b0, robust_max}) - $signed({1'b0, robust_min});
    rneg_mag = 32'(-rs);
    s0_next        = '0;
    s0_next.cmd    = in_data.cmd;
    s0_next.dvalid = in_data.depth_in > 32'sd0;
    s0_next.rpos   = robust_max > robust_min;
    s0_next.rem    = {1'b0, rd - robust_min};
    s0_next.dsor   = robust_max - robust_min;
    s0_next.gnz    = in_data.gray_in != 8'd0;
    s0_next.neg    = gd[8] ^ rs[31];
    s0_next.amag   = gd[8] ? 8'(-gd) : gd[7:0];
    s0_next.rmag   = rs[31] ? rneg_mag[RegW-1:0] : rs[RegW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) st[0] <= s0_next;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    localparam int BI = (k >= 2 && k <= 6) ? 6 - k : 0;
    pipe_t nxt;

    always_comb begin
      logic [32:0]        t;
      logic               ge;
      logic [9:0]         dq;
      logic signed [33:0] d1;
      nxt = st[k];
      // Restoring division step; the first step compares without a shift.
      t   = (k == 0) ? {1'b0, st[k].rem} : {st[k].rem, 1'b0};
      ge  = t >= {2'b0, st[k].dsor};
      t   = ge ? t - {2'b0, st[k].dsor} : t;
      nxt.rem = t[31:0];
      nxt.quo = {st[k].quo[15:0], ge};
      dq = div3_digit(st[k].r3, st[k].x[8*BI +: 8]);
      d1 = '0;
      if (k == 0) begin
        nxt.x = 40'(st[k].amag) * 40'(st[k].rmag);
      end else if (k == 1) begin
        nxt.x = (st[k].x + 40'd96) >> 6;
      end else if (k >= 2 && k <= 6) begin
        nxt.q3 = {st[k].q3[31:0], dq[9:2]};
        nxt.r3 = dq[1:0];
      end else if (k == 7) begin
        d1 = st[k].neg ? $signed({3'b0, robust_min}) - $signed({2'b0, st[k].q3[31:0]})
                       : $signed({3'b0, robust_min}) + $signed({2'b0, st[k].q3[31:0]});
        if (d1 < $signed({3'b0, clamp_min})) d1 = $signed({3'b0, clamp_min});
        if (d1 > $signed({3'b0, clamp_max})) d1 = $signed({3'b0, clamp_max});
        nxt.x = {9'b0, d1[RegW-1:0]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (adv) vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (adv) st[k+1] <= nxt;
    end
  end

  // Output stage: color and gray from the normalized value, depth from the gray to depth path.
  out_item_t out_next;
  always_comb begin
    logic [16:0]        g;
    logic signed [18:0] gs;
    logic [24:0]        gp;
    pipe_t              s;
    s  = st[DivSteps];
    g  = s.rpos ? s.quo : 17'd0;
    gs = $signed({2'b0, g});
    gp = 25'(g) * 25'd192 + 25'd2129920;
    out_next = '0;
    case (cmd_t'(s.cmd))
      CMD_JET: begin
        if (s.dvalid) begin
          out_next.blue  = to_byte(jet_base(gs + 19'sd16384));
          out_next.green = to_byte(jet_base(gs));
          out_next.red   = to_byte(jet_base(gs - 19'sd16384));
        end
      end
      CMD_GRAY: begin
        if (s.dvalid) out_next.gray_out = gp[23:16];
      end
      CMD_DEPTH: begin
        if (s.gnz) begin
          out_next.depth_out   = s.x[RegW-1:0];
          out_next.depth_write = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vld[DivSteps];
  end

  always_ff @(posedge clk) begin
    if (adv) out_data <= out_next;
  end

endmodule
`default_nettype wire
